/* rtl/qqu_pkg.sv */
// Shared types and constants for the quaternion w-reconstruction pipeline.
`timescale 1ns / 1ps

package qqu_pkg;

	localparam int UNITY_DEFAULT = 32750;   // fixed-point value of 1.0
	localparam int COMP_W        = 16;      // component width
	localparam int SQRT_STEPS    = 16;      // one root bit per stage
	localparam int RAD_W         = 31;      // radicand / partial root width
	localparam int SUM_W         = 32;      // sum of three squares

	// Fields that ride alongside the square root pipeline.
	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
		logic                     w_pos;
		logic                     last;
		logic                     clamped;
	} side_t;

endpackage

/* rtl/qqu_sqrt.sv */
// Pipelined digit-by-digit floor square root, one result bit per stage.
`timescale 1ns / 1ps

module qqu_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [qqu_pkg::RAD_W-1:0]   in_rad,
	input  qqu_pkg::side_t              in_side,
	output logic                        out_vld,
	output logic [qqu_pkg::COMP_W-1:0]  out_root,
	output qqu_pkg::side_t              out_side
);
	import qqu_pkg::*;

	// Index 0 is the input; index k holds the result of step k.
	logic [RAD_W-1:0] op_s   [0:SQRT_STEPS];
	logic [RAD_W-1:0] root_s [0:SQRT_STEPS];
	logic             vld_s  [0:SQRT_STEPS];
	side_t            side_s [0:SQRT_STEPS];

	assign op_s[0]   = in_rad;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQRT_STEPS - 1 - i));

		logic [RAD_W-1:0] trial;
		logic             take;
		logic [RAD_W-1:0] op_n;
		logic [RAD_W-1:0] root_n;

		always_comb begin
			trial  = root_s[i] + BIT;
			take   = (op_s[i] >= trial);
			op_n   = take ? (op_s[i] - trial) : op_s[i];
			root_n = take ? ((root_s[i] >> 1) + BIT) : (root_s[i] >> 1);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[i+1]   <= op_n;
				root_s[i+1] <= root_n;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STEPS];
	assign out_root = root_s[SQRT_STEPS][COMP_W-1:0];
	assign out_side = side_s[SQRT_STEPS];

endmodule

/* rtl/quantized_quaternion_unpack_top.sv */
// Rebuilds w of a compressed unit quaternion, one request per cycle unless stalled.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall with qx, qy, qz (signed, UNITY_VALUE = 1.0),
//   w_positive and is_last. A request is taken at a clock edge with in_valid high
//   and in_stall low.
//   Output channel: out_valid / out_stall with x_out, y_out, z_out (copies),
//   w_out = +/- floor(sqrt(UNITY^2 - x^2 - y^2 - z^2)), w_clamped, last_out.
//   When the sum of squares exceeds UNITY^2, w_out is 0 and w_clamped is 1.
// Pipeline: 1 square stage, 1 sum stage, 16 root stages at one bit each and
//   1 output register between acceptance and out_valid.
// Throughput: one request per cycle unless a stall holds the pipeline; every stage
//   is fully pipelined and requests are independent.
// Stall: the whole pipeline shares one advance enable. When the output holds a
//   result and out_stall is high, every stage freezes and in_stall goes high;
//   nothing is dropped or repeated. An empty output register never blocks input.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not
//   reset. No clearing pass is needed.

module quantized_quaternion_unpack_top #(
	parameter int UNITY_VALUE = qqu_pkg::UNITY_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [qqu_pkg::COMP_W-1:0]  qx,
	input  logic signed [qqu_pkg::COMP_W-1:0]  qy,
	input  logic signed [qqu_pkg::COMP_W-1:0]  qz,
	input  logic                               w_positive,
	input  logic                               is_last,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [qqu_pkg::COMP_W-1:0]  x_out,
	output logic signed [qqu_pkg::COMP_W-1:0]  y_out,
	output logic signed [qqu_pkg::COMP_W-1:0]  z_out,
	output logic signed [qqu_pkg::COMP_W-1:0]  w_out,
	output logic                               w_clamped,
	output logic                               last_out
);
	import qqu_pkg::*;

	localparam logic [SUM_W-1:0] UNITY2 = SUM_W'(UNITY_VALUE) * SUM_W'(UNITY_VALUE);

	// Global advance: move whenever the output slot is free or being drained.
	logic en;
	logic vld_out_q;
	assign en       = !vld_out_q || !out_stall;
	assign in_stall = !en;

	// ---------------- stage 1: squares ----------------
	logic signed [2*COMP_W-1:0] px, py, pz;
	assign px = (2*COMP_W)'(qx) * (2*COMP_W)'(qx);
	assign py = (2*COMP_W)'(qy) * (2*COMP_W)'(qy);
	assign pz = (2*COMP_W)'(qz) * (2*COMP_W)'(qz);

	logic             vld_s1;
	logic [RAD_W-1:0] sqx_s1, sqy_s1, sqz_s1;   // each square is at most 2^30
	side_t            side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1          <= px[RAD_W-1:0];
			sqy_s1          <= py[RAD_W-1:0];
			sqz_s1          <= pz[RAD_W-1:0];
			side_s1.x       <= qx;
			side_s1.y       <= qy;
			side_s1.z       <= qz;
			side_s1.w_pos   <= w_positive;
			side_s1.last    <= is_last;
			side_s1.clamped <= 1'b0;
		end
	end

	// ---------------- stage 2: sum, range check, radicand ----------------
	logic [SUM_W-1:0] sum;
	logic             over;
	logic [SUM_W-1:0] diff;
	assign sum  = SUM_W'(sqx_s1) + SUM_W'(sqy_s1) + SUM_W'(sqz_s1);
	assign over = (sum > UNITY2);
	assign diff = UNITY2 - sum;

	// side fields with the range flag folded in
	side_t side_n2;
	always_comb begin
		side_n2         = side_s1;
		side_n2.clamped = over;
	end

	logic             vld_s2;
	logic [RAD_W-1:0] rad_s2;
	side_t            side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2  <= over ? '0 : diff[RAD_W-1:0];
			side_s2 <= side_n2;
		end
	end

	// ---------------- stages 3..18: square root ----------------
	logic              root_vld;
	logic [COMP_W-1:0] root;
	side_t             root_side;

	qqu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_rad   (rad_s2),
		.in_side  (side_s2),
		.out_vld  (root_vld),
		.out_root (root),
		.out_side (root_side)
	);

	// ---------------- output register: apply sign ----------------
	logic signed [COMP_W-1:0] w_n;
	assign w_n = root_side.w_pos ? $signed(root) : -$signed(root);

	logic signed [COMP_W-1:0] x_q, y_q, z_q, w_q;
	logic                     clamp_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_out_q <= root_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q     <= root_side.x;
			y_q     <= root_side.y;
			z_q     <= root_side.z;
			w_q     <= w_n;
			clamp_q <= root_side.clamped;
			last_q  <= root_side.last;
		end
	end

	assign out_valid = vld_out_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;
	assign w_out     = w_q;
	assign w_clamped = clamp_q;
	assign last_out  = last_q;

endmodule

/* rtl/qqu_checker.sv */
// Port-level checks for the quaternion unpack top level, with its bind.
`timescale 1ns / 1ps

module qqu_checker #(
	parameter int UNITY = qqu_pkg::UNITY_DEFAULT
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [qqu_pkg::COMP_W-1:0]  x_out,
	input logic signed [qqu_pkg::COMP_W-1:0]  y_out,
	input logic signed [qqu_pkg::COMP_W-1:0]  z_out,
	input logic signed [qqu_pkg::COMP_W-1:0]  w_out,
	input logic                               w_clamped,
	input logic                               last_out
);
	import qqu_pkg::*;

	localparam longint UNITY2 = longint'(UNITY) * longint'(UNITY);

	longint sq_xyz, sq_w, root_hi;
	assign sq_xyz = longint'(x_out) * longint'(x_out) + longint'(y_out) * longint'(y_out)
		+ longint'(z_out) * longint'(z_out);
	assign sq_w    = longint'(w_out) * longint'(w_out);
	assign root_hi = (longint'(w_out < 0 ? -w_out : w_out) + 1)
		* (longint'(w_out < 0 ? -w_out : w_out) + 1);

	// A held result stays valid with w_out, w_clamped, x_out and last_out unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(w_out) && $stable(w_clamped)
			&& $stable(x_out) && $stable(last_out))
		else $error("held result changed");

	// Input is never blocked while the output slot is empty.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// A clamped result means the squares exceeded unity and w is zero.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_clamped |-> (w_out == 0) && (sq_xyz > UNITY2))
		else $error("bad clamp");

	// An unclamped w is the floor root of the remainder.
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !w_clamped |-> (sq_xyz + sq_w <= UNITY2) && (sq_xyz + root_hi > UNITY2))
		else $error("w is not the floor root");

endmodule

bind quantized_quaternion_unpack_top qqu_checker #(.UNITY(UNITY_VALUE)) u_qqu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.x_out     (x_out),
	.y_out     (y_out),
	.z_out     (z_out),
	.w_out     (w_out),
	.w_clamped (w_clamped),
	.last_out  (last_out)
);

/* verif/tb_quantized_quaternion_unpack_top.sv */
// Testbench for quantized_quaternion_unpack_top: directed table plus random quaternions.
`timescale 1ns / 1ps

module tb_quantized_quaternion_unpack_top;

	import qqu_pkg::*;

	localparam int UNITY = UNITY_DEFAULT;
	localparam longint UNITY_SQ = longint'(UNITY) * longint'(UNITY);
	localparam int MAX_IDLE = 6;
	localparam int DRAIN_CYCLES = 40;   // pipeline is 19 deep, leave margin
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the pipe
	localparam int HOLD_AT = 150;       // results seen before the hold-off starts
	localparam int RAND_BLOCKS = 10;
	localparam int RAND_PER_BLOCK = 60;

	// One rebuilt quaternion as it leaves the block.
	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
		logic signed [COMP_W-1:0] w;
		logic                     clamped;
		logic                     last;
	} quat_res_t;

	// Directed row: request fields plus an optional hand-written w / clamp.
	typedef struct {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
		logic                     wpos;
		logic                     last;
		bit                       typed;
		logic signed [COMP_W-1:0] w;
		logic                     clamped;
	} quat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COMP_W-1:0] qx = '0;
	logic signed [COMP_W-1:0] qy = '0;
	logic signed [COMP_W-1:0] qz = '0;
	logic w_positive = 1'b0;
	logic is_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COMP_W-1:0] x_out;
	logic signed [COMP_W-1:0] y_out;
	logic signed [COMP_W-1:0] z_out;
	logic signed [COMP_W-1:0] w_out;
	logic w_clamped;
	logic last_out;

	// Hand-written expectation that rides along with the current request.
	logic      drv_typed = 1'b0;
	quat_res_t drv_typed_res = '0;

	quat_res_t quat_exp_q[$];    // rebuilt quaternions still owed by the block
	quat_row_t dir_tab[$];
	int        n_err = 0;
	int        n_results = 0;
	bit        idle_on = 1'b1;   // 0: both sides run flat out

	quantized_quaternion_unpack_top #(
		.UNITY_VALUE(UNITY)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.qx         (qx),
		.qy         (qy),
		.qz         (qz),
		.w_positive (w_positive),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.x_out      (x_out),
		.y_out      (y_out),
		.z_out      (z_out),
		.w_out      (w_out),
		.w_clamped  (w_clamped),
		.last_out   (last_out)
	);

	always #5 clk = ~clk;

	// Floor square root, one result bit per step from the top down.
	function automatic longint floor_sqrt(input longint v);
		longint r;
		longint t;
		r = 0;
		for (int b = COMP_W - 1; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// x, y, z pass through; w = +/- floor(sqrt(1 - |v|^2)) in fixed point,
	// forced to 0 with the clamp flag once the squares exceed unity.
	function automatic quat_res_t rebuild_quat(input logic signed [COMP_W-1:0] x,
			input logic signed [COMP_W-1:0] y, input logic signed [COMP_W-1:0] z,
			input logic wpos, input logic last);
		quat_res_t res;
		longint sum;
		longint w;
		sum = longint'(x) * longint'(x) + longint'(y) * longint'(y)
			+ longint'(z) * longint'(z);
		res.x = x;
		res.y = y;
		res.z = z;
		res.last = last;
		if (sum > UNITY_SQ) begin
			res.clamped = 1'b1;
			res.w = '0;
		end else begin
			res.clamped = 1'b0;
			w = floor_sqrt(UNITY_SQ - sum);
			// negating zero gives plain zero, so no special handling
			if (!wpos)
				w = -w;
			res.w = w[COMP_W-1:0];
		end
		return res;
	endfunction

	function automatic void add_row(input int x, input int y, input int z, input bit wpos,
			input bit last, input bit typed, input int w, input bit clamped);
		quat_row_t row;
		row.x = 16'(x);
		row.y = 16'(y);
		row.z = 16'(z);
		row.wpos = wpos;
		row.last = last;
		row.typed = typed;
		row.w = 16'(w);
		row.clamped = clamped;
		dir_tab.push_back(row);
	endfunction

	// Random quaternion: mostly well-formed or close to the unit sphere,
	// with some full-range noise so every input bit toggles.
	task automatic gen_quat(output logic signed [COMP_W-1:0] x,
			output logic signed [COMP_W-1:0] y, output logic signed [COMP_W-1:0] z);
		int kind;
		int a;
		int b;
		int c;
		longint rest;
		kind = $urandom_range(0, 9);
		if (kind <= 1) begin
			a = $urandom;
			b = $urandom;
			c = $urandom;
		end else if (kind <= 4) begin
			// three squares of this size stay just under unity
			a = int'($urandom_range(0, 37800)) - 18900;
			b = int'($urandom_range(0, 37800)) - 18900;
			c = int'($urandom_range(0, 37800)) - 18900;
		end else if (kind <= 8) begin
			// last component lands within a couple of LSBs of the unit sphere
			a = int'($urandom_range(0, 46000)) - 23000;
			b = int'($urandom_range(0, 46000)) - 23000;
			rest = UNITY_SQ - longint'(a) * a - longint'(b) * b;
			c = int'(floor_sqrt(rest)) + int'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1))
				c = -c;
		end else begin
			// near an axis
			a = UNITY + int'($urandom_range(0, 4)) - 2;
			if ($urandom_range(0, 1))
				a = -a;
			b = int'($urandom_range(0, 2)) - 1;
			c = 0;
		end
		case ($urandom_range(0, 2))
			0: begin
				x = 16'(a); y = 16'(b); z = 16'(c);
			end
			1: begin
				x = 16'(c); y = 16'(a); z = 16'(b);
			end
			default: begin
				x = 16'(b); y = 16'(c); z = 16'(a);
			end
		endcase
	endtask

	// Offer one request, after a random gap if idle_on; returns at the edge that takes it.
	task automatic send_quat(input logic signed [COMP_W-1:0] x,
			input logic signed [COMP_W-1:0] y, input logic signed [COMP_W-1:0] z,
			input logic wpos, input logic last, input bit typed, input quat_res_t typed_res);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		qx <= x;
		qy <= y;
		qz <= z;
		w_positive <= wpos;
		is_last <= last;
		drv_typed <= typed;
		drv_typed_res <= typed_res;
		do @(posedge clk); while (in_stall);
	endtask

	// Sender stops offering until every owed result is out.
	task automatic drain_quats();
		@(negedge clk);
		in_valid <= 1'b0;
		while (quat_exp_q.size() != 0)
			@(posedge clk);
	endtask

	// Acceptance on both channels. Requests are logged first so an output
	// in the same cycle still finds its expectation.
	always @(posedge clk) begin
		quat_res_t got;
		quat_res_t want;
		if (arst_n && in_valid && !in_stall) begin
			if (drv_typed)
				quat_exp_q.push_back(drv_typed_res);
			else
				quat_exp_q.push_back(rebuild_quat(qx, qy, qz, w_positive, is_last));
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			got = '{x_out, y_out, z_out, w_out, w_clamped, last_out};
			if (quat_exp_q.size() == 0) begin
				$error("result with nothing pending: x %0d y %0d z %0d w %0d",
					x_out, y_out, z_out, w_out);
				n_err++;
			end else begin
				want = quat_exp_q.pop_front();
				if (got.x !== want.x) begin
					$error("x_out: expected %0d, got %0d", want.x, got.x);
					n_err++;
				end
				if (got.y !== want.y) begin
					$error("y_out: expected %0d, got %0d", want.y, got.y);
					n_err++;
				end
				if (got.z !== want.z) begin
					$error("z_out: expected %0d, got %0d", want.z, got.z);
					n_err++;
				end
				if (got.w !== want.w) begin
					$error("w_out: expected %0d, got %0d", want.w, got.w);
					n_err++;
				end
				if (got.clamped !== want.clamped) begin
					$error("w_clamped: expected %0d, got %0d", want.clamped, got.clamped);
					n_err++;
				end
				if (got.last !== want.last) begin
					$error("last_out: expected %0d, got %0d", want.last, got.last);
					n_err++;
				end
			end
		end
	end

	// Output side: random stall before each result when idle_on is set, one long
	// hold-off part way through so the pipe backs up into in_stall.
	initial begin
		int n;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_results >= HOLD_AT) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
			end
			n = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
			repeat (n) @(negedge clk) out_stall <= 1'b1;
			@(negedge clk) out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Main sequence: reset, directed table, random blocks, drain, verdict.
	initial begin
		logic signed [COMP_W-1:0] rx;
		logic signed [COMP_W-1:0] ry;
		logic signed [COMP_W-1:0] rz;
		quat_res_t exp_row;

		// typed rows: zero vector, exact unity, clamp cases
		add_row(0, 0, 0, 1, 0, 1, UNITY, 0);
		add_row(0, 0, 0, 0, 1, 1, -UNITY, 0);
		add_row(UNITY, 0, 0, 1, 0, 1, 0, 0);
		add_row(0, -UNITY, 0, 0, 1, 1, 0, 0);     // negative zero comes out as 0
		add_row(0, 0, UNITY, 0, 0, 1, 0, 0);
		add_row(-32768, -32768, -32768, 1, 1, 1, 0, 1);
		add_row(32767, 32767, 32767, 0, 0, 1, 0, 1);
		add_row(32767, 0, 0, 1, 0, 1, 0, 1);
		add_row(UNITY, 1, 0, 0, 1, 1, 0, 1);       // one LSB past unity
		add_row(-32768, 0, 0, 0, 0, 1, 0, 1);
		add_row(18909, -18909, 18909, 0, 0, 1, 0, 1);
		// predicted rows: just inside unity and bit patterns
		add_row(32749, 0, 0, 1, 0, 0, 0, 0);
		add_row(0, 32749, 0, 0, 1, 0, 0, 0);
		add_row(18908, 18908, 18908, 1, 0, 0, 0, 0);
		add_row(1, -1, 1, 1, 1, 0, 0, 0);
		add_row(21845, -21846, 0, 1, 0, 0, 0, 0);
		add_row(-21846, 0, 21845, 0, 1, 0, 0, 0);
		add_row(0, 255, -256, 1, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		idle_on = 1'b1;
		foreach (dir_tab[i]) begin
			exp_row = '{dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].w,
				dir_tab[i].clamped, dir_tab[i].last};
			send_quat(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].wpos,
				dir_tab[i].last, dir_tab[i].typed, exp_row);
		end
		drain_quats();

		// every third block runs with no idling on either side
		for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
			idle_on = (blk % 3) != 2;
			for (int k = 0; k < RAND_PER_BLOCK; k++) begin
				gen_quat(rx, ry, rz);
				send_quat(rx, ry, rz, 1'($urandom_range(0, 1)),
					$urandom_range(0, 7) == 0, 1'b0, '0);
			end
			if (blk == RAND_BLOCKS / 2)
				drain_quats();
		end

		@(negedge clk) in_valid <= 1'b0;
		while (quat_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_err == 0)
			$display("PASS quantized_quaternion_unpack_top");
		else
			$display("FAIL quantized_quaternion_unpack_top");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAIL quantized_quaternion_unpack_top");
		$finish;
	end

endmodule

/* files.f */
rtl/qqu_pkg.sv
rtl/qqu_sqrt.sv
rtl/quantized_quaternion_unpack_top.sv
rtl/qqu_checker.sv
verif/tb_quantized_quaternion_unpack_top.sv
